FILE: hdl/tcq_pkg.sv
package tcq_pkg;

	localparam int TIME_W          = 16;
	localparam int MODE_W          = 2;
	localparam int LEN_W           = 8;
	localparam int HOLD_W          = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int CAL_SAMPLES_DEF = 10;

	localparam logic [TIME_W-1:0] GATE_MARGIN_RST = 16'd100;
	localparam logic [LEN_W-1:0]  SINGLE_LEN_RST  = 8'd3;
	localparam logic [LEN_W-1:0]  REPEAT_LEN_RST  = 8'd6;
	localparam logic [TIME_W-1:0] HALF_SCALE      = 16'h7FFF;
	localparam logic [HOLD_W-1:0] HOLDOFF_RELOAD  = 2'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_CAL,
		MODE_SINGLE,
		MODE_REPEAT,
		MODE_SKIP
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATE_MARGIN,
		REG_SINGLE_LEN,
		REG_REPEAT_LEN
	} reg_idx_t;

	typedef enum logic {
		EV_CAL,
		EV_SCAN
	} ev_kind_t;

	typedef struct packed {
		logic [TIME_W-1:0] gate_margin;
		logic [LEN_W-1:0]  single_len;
		logic [LEN_W-1:0]  repeat_len;
	} cfg_t;

	// one finished calibration set or scan group travelling down the pipe
	typedef struct packed {
		ev_kind_t          kind;
		logic              rpt;
		logic [TIME_W-1:0] peak;
	} ev_t;

endpackage

FILE: hdl/tcq_item_if.sv
interface tcq_item_if import tcq_pkg::*;;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [TIME_W-1:0] charge_time;

	modport source (output valid, output mode, output charge_time, input ready);
	modport sink (input valid, input mode, input charge_time, output ready);
endinterface

FILE: hdl/tcq_result_if.sv
interface tcq_result_if import tcq_pkg::*;;
	logic              valid;
	logic              ready;
	logic              event_kind;
	logic              touched;
	logic              calib_failed;
	logic [TIME_W-1:0] level;

	modport source (output valid, output event_kind, output touched, output calib_failed,
		output level, input ready);
	modport sink (input valid, input event_kind, input touched, input calib_failed,
		input level, output ready);
endinterface

FILE: hdl/tcq_cfg_if.sv
interface tcq_cfg_if import tcq_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: hdl/capacitive_touch_qualifier_top.sv
// a result is presented from the decide register once the transaction that completes its
// calibration set or scan group has passed the input, accumulate, trim and divide registers
// throughput: one charge-time sample per cycle; the pipe stalls only when the result is not taken
// the trimmed mean uses a reciprocal multiply in its own stage
// reset (arst_n low): baseline, hold-off, accumulators and pipe cleared,
// registers return to gate margin 100, single length 3, repeat length 6
module capacitive_touch_qualifier_top import tcq_pkg::*; #(
	parameter int  CAL_SAMPLES = CAL_SAMPLES_DEF,
	localparam int SUM_W       = TIME_W + $clog2(CAL_SAMPLES)
) (
	input  logic          clk,
	input  logic          arst_n,
	tcq_item_if.sink      item,
	tcq_result_if.source  result,
	tcq_cfg_if.sink       cfg
);

	cfg_t                   cfg_q;

	logic                   valid_s2;
	logic                   ready_s2;
	ev_t                    ev_s2;
	logic [SUM_W-1:0]       sum_s2;
	logic [1:0][TIME_W-1:0] lo_s2;
	logic [1:0][TIME_W-1:0] hi_s2;
	logic                   valid_s4;
	logic                   ready_s4;
	ev_t                    ev_s4;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_margin <= GATE_MARGIN_RST;
			cfg_q.single_len  <= SINGLE_LEN_RST;
			cfg_q.repeat_len  <= REPEAT_LEN_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_GATE_MARGIN: cfg_q.gate_margin <= cfg.wdata;
				REG_SINGLE_LEN:  cfg_q.single_len  <= cfg.wdata[LEN_W-1:0];
				REG_REPEAT_LEN:  cfg_q.repeat_len  <= cfg.wdata[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tcq_accum #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_mode  (item.mode),
		.in_time  (item.charge_time),
		.cfg      (cfg_q),
		.valid_s2 (valid_s2),
		.dn_ready (ready_s2),
		.ev_s2    (ev_s2),
		.sum_s2   (sum_s2),
		.lo_s2    (lo_s2),
		.hi_s2    (hi_s2)
	);

	tcq_div #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.up_ready (ready_s2),
		.ev_s2    (ev_s2),
		.sum_s2   (sum_s2),
		.lo_s2    (lo_s2),
		.hi_s2    (hi_s2),
		.valid_s4 (valid_s4),
		.dn_ready (ready_s4),
		.ev_s4    (ev_s4)
	);

	tcq_decide u_decide (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s4    (valid_s4),
		.up_ready    (ready_s4),
		.ev_s4       (ev_s4),
		.cfg         (cfg_q),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_kind    (result.event_kind),
		.out_touched (result.touched),
		.out_failed  (result.calib_failed),
		.out_level   (result.level)
	);

endmodule

FILE: hdl/tcq_accum.sv
module tcq_accum import tcq_pkg::*; #(
	parameter int  CAL_SAMPLES = CAL_SAMPLES_DEF,
	localparam int CNT_W       = $clog2(CAL_SAMPLES),
	localparam int SUM_W       = TIME_W + $clog2(CAL_SAMPLES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [MODE_W-1:0]          in_mode,
	input  logic [TIME_W-1:0]          in_time,
	input  cfg_t                       cfg,
	output logic                       valid_s2,
	input  logic                       dn_ready,
	output ev_t                        ev_s2,
	output logic [SUM_W-1:0]           sum_s2,
	output logic [1:0][TIME_W-1:0]     lo_s2,
	output logic [1:0][TIME_W-1:0]     hi_s2
);

	logic              valid_s1;
	mode_t             mode_s1;
	logic [TIME_W-1:0] time_s1;

	logic [CNT_W-1:0]          cal_cnt_q;
	logic [SUM_W-1:0]          cal_sum_q;
	logic [1:0][TIME_W-1:0]    cal_lo_q;
	logic [1:0][TIME_W-1:0]    cal_hi_q;
	logic [LEN_W-1:0]          grp_cnt_q;
	logic [LEN_W-1:0]          grp_tgt_q;
	logic                      grp_rpt_q;
	logic [TIME_W-1:0]         grp_peak_q;

	logic                      is_cal;
	logic                      is_scan;
	logic                      cal_last;
	logic [SUM_W-1:0]          sum_n;
	logic [1:0][TIME_W-1:0]    lo_n;
	logic [1:0][TIME_W-1:0]    hi_n;
	logic                      grp_open;
	logic [LEN_W-1:0]          len_sel;
	logic [LEN_W-1:0]          tgt_n;
	logic                      rpt_n;
	logic [TIME_W-1:0]         peak_base;
	logic [TIME_W-1:0]         peak_n;
	logic [LEN_W-1:0]          cnt_inc;
	logic                      grp_last;
	logic                      ld_s2;
	logic                      fire;

	always_comb begin
		unique case (mode_s1)
			MODE_CAL: begin
				is_cal  = 1'b1;
				is_scan = 1'b0;
			end
			MODE_SINGLE, MODE_REPEAT: begin
				is_cal  = 1'b0;
				is_scan = 1'b1;
			end
			default: begin
				is_cal  = 1'b0;
				is_scan = 1'b0;
			end
		endcase

		// two smallest and two largest of the set, kept sorted
		lo_n = cal_lo_q;
		if (time_s1 < cal_lo_q[0]) begin
			lo_n[1] = cal_lo_q[0];
			lo_n[0] = time_s1;
		end else if (time_s1 < cal_lo_q[1]) begin
			lo_n[1] = time_s1;
		end
		hi_n = cal_hi_q;
		if (time_s1 > cal_hi_q[0]) begin
			hi_n[1] = cal_hi_q[0];
			hi_n[0] = time_s1;
		end else if (time_s1 > cal_hi_q[1]) begin
			hi_n[1] = time_s1;
		end
		sum_n    = cal_sum_q + SUM_W'(time_s1);
		cal_last = (cal_cnt_q == CNT_W'(CAL_SAMPLES - 1));

		// a scan group takes length and mode when it opens
		grp_open  = (grp_cnt_q == '0);
		len_sel   = (mode_s1 == MODE_REPEAT) ? cfg.repeat_len : cfg.single_len;
		tgt_n     = grp_tgt_q;
		rpt_n     = grp_rpt_q;
		peak_base = grp_peak_q;
		if (grp_open) begin
			tgt_n     = (len_sel == '0) ? LEN_W'(1) : len_sel;
			rpt_n     = (mode_s1 == MODE_REPEAT);
			peak_base = '0;
		end
		peak_n   = (time_s1 > peak_base) ? time_s1 : peak_base;
		cnt_inc  = grp_cnt_q + LEN_W'(1);
		grp_last = (cnt_inc >= tgt_n);

		ld_s2    = !valid_s2 || dn_ready;
		in_ready = !valid_s1 || ld_s2;
		fire     = valid_s1 && ld_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			cal_cnt_q  <= '0;
			cal_sum_q  <= '0;
			cal_lo_q   <= '1;
			cal_hi_q   <= '0;
			grp_cnt_q  <= '0;
			grp_tgt_q  <= '0;
			grp_rpt_q  <= 1'b0;
			grp_peak_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ld_s2) begin
				valid_s2 <= fire && ((is_cal && cal_last) || (is_scan && grp_last));
			end
			if (fire && is_cal) begin
				if (cal_last) begin
					cal_cnt_q <= '0;
					cal_sum_q <= '0;
					cal_lo_q  <= '1;
					cal_hi_q  <= '0;
				end else begin
					cal_cnt_q <= cal_cnt_q + CNT_W'(1);
					cal_sum_q <= sum_n;
					cal_lo_q  <= lo_n;
					cal_hi_q  <= hi_n;
				end
			end
			if (fire && is_scan) begin
				grp_cnt_q  <= grp_last ? '0 : cnt_inc;
				grp_tgt_q  <= tgt_n;
				grp_rpt_q  <= rpt_n;
				grp_peak_q <= peak_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			mode_s1 <= mode_t'(in_mode);
			time_s1 <= in_time;
		end
		if (ld_s2) begin
			ev_s2.kind <= is_cal ? EV_CAL : EV_SCAN;
			ev_s2.rpt  <= rpt_n;
			ev_s2.peak <= peak_n;
			sum_s2     <= sum_n;
			lo_s2      <= lo_n;
			hi_s2      <= hi_n;
		end
	end

`ifndef SYNTHESIS
	a_cal_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_cnt_q <= CNT_W'(CAL_SAMPLES - 1))
		else $error("calibration count past set size");
	a_extremes_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cal_lo_q[0] <= cal_lo_q[1] && cal_hi_q[0] >= cal_hi_q[1])
		else $error("calibration extremes out of order");
	a_cal_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_cal && cal_last |=> cal_cnt_q == '0 && cal_sum_q == '0)
		else $error("calibration set not cleared after last sample");
`endif

endmodule

FILE: hdl/tcq_div.sv
module tcq_div import tcq_pkg::*; #(
	parameter int  CAL_SAMPLES = CAL_SAMPLES_DEF,
	localparam int SUM_W       = TIME_W + $clog2(CAL_SAMPLES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s2,
	output logic                   up_ready,
	input  ev_t                    ev_s2,
	input  logic [SUM_W-1:0]       sum_s2,
	input  logic [1:0][TIME_W-1:0] lo_s2,
	input  logic [1:0][TIME_W-1:0] hi_s2,
	output logic                   valid_s4,
	input  logic                   dn_ready,
	output ev_t                    ev_s4
);

	// floor(n / DIVISOR) as (n * RECIP) >> SHIFT, exact for every n below 2**SUM_W
	localparam int DIVISOR = CAL_SAMPLES - 4;
	localparam int FRAC    = $clog2(DIVISOR);
	localparam int SHIFT   = SUM_W + FRAC;
	localparam int RCP_W   = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RCP_W;
	localparam longint unsigned RECIP_VAL =
		((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_VAL);

	logic              valid_s3;
	ev_t               ev_s3;
	logic [SUM_W-1:0]  trim_s3;

	logic [SUM_W-1:0]  trim;
	logic [PROD_W-1:0] prod;
	logic [TIME_W-1:0] quot;
	logic              ld_s3;
	logic              ld_s4;

	always_comb begin
		trim = sum_s2 - SUM_W'(lo_s2[0]) - SUM_W'(lo_s2[1])
			- SUM_W'(hi_s2[0]) - SUM_W'(hi_s2[1]);
		prod = PROD_W'(trim_s3) * PROD_W'(RECIP);
		quot = prod[SHIFT +: TIME_W];

		ld_s4    = !valid_s4 || dn_ready;
		ld_s3    = !valid_s3 || ld_s4;
		up_ready = ld_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ld_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ld_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			ev_s3   <= ev_s2;
			trim_s3 <= trim;
		end
		if (ld_s4) begin
			ev_s4.kind <= ev_s3.kind;
			ev_s4.rpt  <= ev_s3.rpt;
			ev_s4.peak <= (ev_s3.kind == EV_CAL) ? quot : ev_s3.peak;
		end
	end

`ifndef SYNTHESIS
	a_s4_follows_s3: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s4 && valid_s3 |=> valid_s4)
		else $error("divider stage dropped a transaction");
	a_scan_level_passes: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s4 && valid_s3 && ev_s3.kind == EV_SCAN |=> ev_s4.peak == $past(ev_s3.peak))
		else $error("scan peak altered in divider stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !dn_ready |=> valid_s4 && $stable(ev_s4))
		else $error("stalled divider output changed");
`endif

endmodule

FILE: hdl/tcq_decide.sv
module tcq_decide import tcq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s4,
	output logic              up_ready,
	input  ev_t               ev_s4,
	input  cfg_t              cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_kind,
	output logic              out_touched,
	output logic              out_failed,
	output logic [TIME_W-1:0] out_level
);

	logic [TIME_W-1:0] baseline_q;
	logic [HOLD_W-1:0] holdoff_q;
	logic              valid_q;
	logic              kind_q;
	logic              touched_q;
	logic              failed_q;
	logic [TIME_W-1:0] level_q;

	logic              ld;
	logic              fire;
	logic [TIME_W:0]   thresh;
	logic              hit;
	logic [HOLD_W-1:0] hold_base;
	logic [HOLD_W-1:0] hold_hit;
	logic [HOLD_W-1:0] hold_n;
	logic              touch_n;

	always_comb begin
		ld       = !valid_q || out_ready;
		up_ready = ld;
		fire     = valid_s4 && ld;

		// threshold is taken one bit wider so it never wraps
		thresh    = {1'b0, baseline_q} + {1'b0, cfg.gate_margin};
		hit       = {1'b0, ev_s4.peak} > thresh;
		hold_base = ev_s4.rpt ? '0 : holdoff_q;
		touch_n   = hit && (hold_base == '0);
		hold_hit  = hit ? HOLDOFF_RELOAD : hold_base;
		hold_n    = (hold_hit != '0) ? hold_hit - HOLD_W'(1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			baseline_q <= '0;
			holdoff_q  <= '0;
		end else begin
			if (ld) begin
				valid_q <= valid_s4;
			end
			if (fire) begin
				if (ev_s4.kind == EV_CAL) begin
					baseline_q <= ev_s4.peak;
				end else begin
					holdoff_q <= hold_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			kind_q    <= ev_s4.kind;
			level_q   <= ev_s4.peak;
			touched_q <= (ev_s4.kind == EV_SCAN) && touch_n;
			failed_q  <= (ev_s4.kind == EV_CAL) && (ev_s4.peak > HALF_SCALE);
		end
	end

	assign out_valid   = valid_q;
	assign out_kind    = kind_q;
	assign out_touched = touched_q;
	assign out_failed  = failed_q;
	assign out_level   = level_q;

`ifndef SYNTHESIS
	a_holdoff_never_reload: assert property (@(posedge clk) disable iff (!arst_n)
		holdoff_q != HOLDOFF_RELOAD)
		else $error("hold-off left at reload value after a group");
	a_baseline_load: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ev_s4.kind == EV_CAL |=> baseline_q == $past(ev_s4.peak))
		else $error("baseline not taken from calibration result");
	a_flags_by_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> !(touched_q && kind_q == EV_CAL) && !(failed_q && kind_q == EV_SCAN))
		else $error("result flag set for the wrong event kind");
	a_touch_sets_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ev_s4.kind == EV_SCAN && hit |=> holdoff_q == HOLDOFF_RELOAD - HOLD_W'(1))
		else $error("touching group did not restart hold-off");
`endif

endmodule

FILE: test/capacitive_touch_qualifier_top_tb.sv
module capacitive_touch_qualifier_top_tb import tcq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAL_N = CAL_SAMPLES_DEF;

	typedef struct {
		mode_t             mode;
		logic [TIME_W-1:0] charge;
	} sample_t;

	typedef struct {
		ev_kind_t          kind;
		logic              touched;
		logic              failed;
		logic [TIME_W-1:0] level;
	} touch_event_t;

	logic clk;
	logic arst_n;

	tcq_item_if   sample_ch();
	tcq_result_if event_ch();
	tcq_cfg_if    reg_ch();

	capacitive_touch_qualifier_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (sample_ch),
		.result (event_ch),
		.cfg    (reg_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// samples waiting for the driver, events waiting for the block
	sample_t      sample_queue[$];
	touch_event_t event_queue[$];

	// register copies
	logic [TIME_W-1:0] gate_margin_cfg;
	logic [LEN_W-1:0]  single_len_cfg;
	logic [LEN_W-1:0]  repeat_len_cfg;

	// qualifier state
	logic [TIME_W-1:0] baseline    = '0;
	logic [HOLD_W-1:0] holdoff     = '0;
	logic [LEN_W-1:0]  grp_count   = '0;
	logic [LEN_W-1:0]  grp_target  = '0;
	logic              grp_repeat  = 1'b0;
	logic [TIME_W-1:0] grp_peak    = '0;
	logic [5:0]        cal_count   = '0;
	logic [21:0]       cal_sum     = '0;
	logic [TIME_W-1:0] cal_low[2]  = '{default: '1};
	logic [TIME_W-1:0] cal_high[2] = '{default: '0};

	int  n_pushed_all;
	int  n_taken_all;
	int  n_queued;
	int  n_samples_taken;
	int  n_cal_events;
	int  n_cal_failed;
	int  n_groups;
	int  n_touches;
	int  err_count;
	int  pad_nominal;
	bit  item_took;
	bit  rx_hold;
	bit  hold_go;

	task automatic clear_calibration();
		cal_count  = '0;
		cal_sum    = '0;
		cal_low[0] = '1;
		cal_low[1] = '1;
		cal_high[0] = '0;
		cal_high[1] = '0;
	endtask

	task automatic qualify_sample(input mode_t m, input logic [TIME_W-1:0] t);
		logic [21:0]       trimmed;
		logic [LEN_W-1:0]  len;
		logic [TIME_W:0]   thresh;
		logic              hit;
		case (m)
			MODE_CAL: begin
				if (t < cal_low[0]) begin
					cal_low[1] = cal_low[0];
					cal_low[0] = t;
				end else if (t < cal_low[1]) begin
					cal_low[1] = t;
				end
				if (t > cal_high[0]) begin
					cal_high[1] = cal_high[0];
					cal_high[0] = t;
				end else if (t > cal_high[1]) begin
					cal_high[1] = t;
				end
				cal_sum   = cal_sum + 22'(t);
				cal_count = cal_count + 6'd1;
				if (cal_count >= CAL_N || cal_count == 0) begin
					trimmed = cal_sum - 22'(cal_low[0]) - 22'(cal_low[1])
						- 22'(cal_high[0]) - 22'(cal_high[1]);
					baseline = TIME_W'(trimmed / (CAL_N - 4));
					clear_calibration();
					event_queue.push_back('{EV_CAL, 1'b0, baseline > HALF_SCALE, baseline});
					n_cal_events++;
					if (baseline > HALF_SCALE) n_cal_failed++;
				end
			end
			MODE_SKIP: ;
			default: begin
				if (grp_count == 0) begin
					len = (m == MODE_REPEAT) ? repeat_len_cfg : single_len_cfg;
					if (len == 0) len = 8'd1;
					grp_target = len;
					grp_repeat = (m == MODE_REPEAT);
					grp_peak   = '0;
				end
				if (t > grp_peak) grp_peak = t;
				grp_count = grp_count + 8'd1;
				if (grp_count >= grp_target) begin
					hit    = 1'b0;
					thresh = {1'b0, baseline} + {1'b0, gate_margin_cfg};
					if (grp_repeat) holdoff = '0;
					if ({1'b0, grp_peak} > thresh) begin
						if (holdoff == 0) hit = 1'b1;
						holdoff = HOLDOFF_RELOAD;
					end
					if (holdoff != 0) holdoff = holdoff - 2'd1;
					grp_count = '0;
					event_queue.push_back('{EV_SCAN, hit, 1'b0, grp_peak});
					n_groups++;
					if (hit) n_touches++;
				end
			end
		endcase
	endtask

	function automatic int sender_idle_pct();
		if (n_samples_taken < 450) return 37;
		if (n_samples_taken < 900) return 85;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (n_samples_taken < 450) return 85;
		if (n_samples_taken < 900) return 37;
		return 0;
	endfunction

	always @(negedge clk) begin : drive_samples
		sample_t s;
		if (arst_n) begin
			if (!sample_ch.valid || item_took) begin
				if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
					s = sample_queue.pop_front();
					sample_ch.valid       <= 1'b1;
					sample_ch.mode        <= s.mode;
					sample_ch.charge_time <= s.charge;
				end else begin
					sample_ch.valid       <= 1'b0;
					sample_ch.mode        <= MODE_W'($urandom);
					sample_ch.charge_time <= TIME_W'($urandom);
				end
			end
			event_ch.ready <= !rx_hold && ($urandom_range(99) >= receiver_idle_pct());
		end else begin
			sample_ch.valid       <= 1'b0;
			sample_ch.mode        <= MODE_CAL;
			sample_ch.charge_time <= '0;
			event_ch.ready        <= 1'b0;
		end
	end

	always @(posedge clk) begin : watch_events
		touch_event_t ev;
		item_took <= arst_n && sample_ch.valid && sample_ch.ready;
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			qualify_sample(mode_t'(sample_ch.mode), sample_ch.charge_time);
			n_taken_all++;
			if (sample_ch.mode != MODE_SKIP) n_samples_taken++;
		end
		if (arst_n && event_ch.valid && event_ch.ready) begin
			if (event_queue.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("%0t: unexpected event kind %0d touched %0d failed %0d level %0d",
						$time, event_ch.event_kind, event_ch.touched, event_ch.calib_failed,
						event_ch.level);
			end else begin
				ev = event_queue.pop_front();
				if (event_ch.event_kind !== ev.kind || event_ch.touched !== ev.touched ||
						event_ch.calib_failed !== ev.failed || event_ch.level !== ev.level) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: expected kind %0d touched %0d failed %0d level %0d, %s %0d %0d %0d %0d",
							$time, ev.kind, ev.touched, ev.failed, ev.level, "got",
							event_ch.event_kind, event_ch.touched, event_ch.calib_failed,
							event_ch.level);
				end
			end
		end
	end

	// long receiver stall so the pipe backs up into the input
	initial begin : rx_hold_ctl
		rx_hold = 1'b0;
		wait (hold_go);
		rx_hold = 1'b1;
		repeat (200) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic push_sample(input mode_t m, input logic [TIME_W-1:0] t);
		sample_queue.push_back('{m, t});
		n_pushed_all++;
		if (m != MODE_SKIP) n_queued++;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (n_taken_all != n_pushed_all || event_queue.size() != 0);
		// groups still open leave no event behind, give the pipe time to empty
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.wdata <= val;
		do @(posedge clk); while (!reg_ch.ready);
		case (idx)
			REG_GATE_MARGIN: gate_margin_cfg = val;
			REG_SINGLE_LEN:  single_len_cfg  = val[LEN_W-1:0];
			REG_REPEAT_LEN:  repeat_len_cfg  = val[LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		reg_ch.valid <= 1'b0;
	endtask

	task automatic apply_setting(input logic [TIME_W-1:0] margin, input logic [LEN_W-1:0] slen,
			input logic [LEN_W-1:0] rlen);
		wait_drained();
		write_reg(REG_GATE_MARGIN, margin);
		// junk in the upper byte must be dropped by the length registers
		write_reg(REG_SINGLE_LEN, {8'($urandom), slen});
		write_reg(REG_REPEAT_LEN, {8'($urandom), rlen});
	endtask

	function automatic logic [TIME_W-1:0] pad_sample(input bit finger);
		int v;
		if ($urandom_range(11) == 0) return TIME_W'($urandom);
		v = pad_nominal + int'($urandom_range(80)) - 40;
		if (finger) v += int'(gate_margin_cfg) + int'($urandom_range(600)) - 100;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return TIME_W'(v);
	endfunction

	task automatic gen_burst(inout bit finger);
		int    r;
		int    len;
		mode_t m;
		r = $urandom_range(99);
		if (r < 18) begin
			for (int i = 0; i < CAL_N; i++)
				push_sample(MODE_CAL, ($urandom_range(9) == 0) ? TIME_W'($urandom) : pad_sample(1'b0));
		end else if (r < 88) begin
			m   = $urandom_range(1) ? MODE_REPEAT : MODE_SINGLE;
			len = (m == MODE_REPEAT) ? repeat_len_cfg : single_len_cfg;
			if (len == 0) len = 1;
			if ($urandom_range(3) == 0) finger = !finger;
			for (int i = 0; i < len; i++) push_sample(m, pad_sample(finger));
		end else begin
			repeat ($urandom_range(3, 1)) push_sample(mode_t'($urandom_range(3)), TIME_W'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [TIME_W-1:0] margin;
		logic [LEN_W-1:0]  slen;
		logic [LEN_W-1:0]  rlen;
		int                budget;
		int                goal;
		bit                squeeze;
		bit                finger;
		arst_n                = 1'b0;
		hold_go               = 1'b0;
		reg_ch.valid          = 1'b0;
		reg_ch.index          = REG_GATE_MARGIN;
		reg_ch.wdata          = '0;
		gate_margin_cfg       = GATE_MARGIN_RST;
		single_len_cfg        = SINGLE_LEN_RST;
		repeat_len_cfg        = REPEAT_LEN_RST;
		finger = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// scan group open while calibration and a mode change and a skipped sample arrive
		push_sample(MODE_SINGLE, 16'd0);
		push_sample(MODE_CAL, 16'd0);
		push_sample(MODE_REPEAT, 16'hFFFF);
		push_sample(MODE_SKIP, 16'hFFFF);
		push_sample(MODE_SINGLE, 16'd1);
		// calibration set whose baseline lands above half scale
		push_sample(MODE_CAL, 16'hFFFF);
		push_sample(MODE_CAL, 16'hFFFF);
		push_sample(MODE_CAL, 16'd0);
		for (int k = 0; k < 6; k++) push_sample(MODE_CAL, 16'(50000 + k));
		// hold-off swallows the next touching group
		repeat (3) push_sample(MODE_SINGLE, 16'hFFFF);
		// length zero behaves as one, full margin blocks every touch
		apply_setting(16'hFFFF, 8'd0, 8'd0);
		push_sample(MODE_SINGLE, 16'hFFFF);
		push_sample(MODE_REPEAT, 16'hFFFF);
		apply_setting(16'd0, 8'd0, 8'd0);
		push_sample(MODE_REPEAT, 16'd50003);
		push_sample(MODE_REPEAT, 16'd50002);
		push_sample(MODE_SINGLE, 16'd50003);
		push_sample(MODE_SINGLE, 16'd50003);

		for (int p = 0; p < 8; p++) begin
			squeeze = 1'b0;
			case (p)
				0: begin margin = GATE_MARGIN_RST; slen = SINGLE_LEN_RST; rlen = REPEAT_LEN_RST;
					budget = 200; end
				1: begin margin = 16'($urandom_range(400, 20)); slen = 8'd1; rlen = 8'd2;
					budget = 200; end
				2: begin margin = 16'd0; slen = 8'd255; rlen = 8'd255; budget = 260; end
				3: begin margin = 16'hFFFF; slen = 8'd0; rlen = 8'd0; budget = 150; end
				4: begin margin = 16'($urandom_range(300, 50)); slen = 8'd1; rlen = 8'd1;
					budget = 150; squeeze = 1'b1; end
				default: begin
					margin = 16'($urandom_range(600));
					slen   = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(12, 1));
					rlen   = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(12, 1));
					budget = 120;
				end
			endcase
			apply_setting(margin, slen, rlen);
			pad_nominal = $urandom_range(45000, 300);
			if (squeeze) hold_go = 1'b1;
			goal = n_queued + budget;
			while (n_queued < goal) begin
				gen_burst(finger);
				if ($urandom_range(29) == 0) wait_drained();
			end
		end

		wait_drained();
		$display("run covered %0d samples: %0d calibrations (%0d over half scale),",
			n_samples_taken, n_cal_events, n_cal_failed);
		$display("%0d scan groups with %0d touches, %0d mismatches", n_groups, n_touches,
			err_count);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
